// ===== hdl/twcw_pkg.sv =====
// twcw_pkg: shared types, constants and helpers for the textured wall column walker
// no dependencies; imported by every module of the walker
`timescale 1ns / 1ps

package twcw_pkg;

  // default fixed-point and row widths
  localparam int TWCW_FRAC_BITS = 16;
  localparam int TWCW_ROW_BITS  = 12;

  // fixed field and datapath widths
  localparam int LH_W   = 24;               // line height, saturated
  localparam int DEN_W  = LH_W + 1;         // divisor: distance or line height plus one
  localparam int OFF_W  = LH_W - 1;         // clipped top offset, half a line height
  localparam int TEXD_W = 11;               // texture dimension register
  localparam int TCOL_W = 10;               // texture column

  localparam logic [LH_W-1:0]   LH_MAX       = '1;
  localparam logic [TEXD_W-1:0] TEX_SIZE_MAX = 11'd1024;

  // reset values of the configuration registers
  localparam logic [11:0]       SCREEN_H_RST = 12'd480;
  localparam logic [TEXD_W-1:0] TEX_W_RST    = 11'd64;
  localparam logic [TEXD_W-1:0] TEX_H_RST    = 11'd64;

  // configuration register indexes
  localparam logic [1:0] CFG_SCREEN_HEIGHT  = 2'd0;
  localparam logic [1:0] CFG_TEXTURE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_TEXTURE_HEIGHT = 2'd2;

  // input word modes and hit kinds
  localparam logic MODE_SETUP = 1'b0;
  localparam logic MODE_ROW   = 1'b1;
  localparam logic [1:0] HIT_PILLAR = 2'd2;
  localparam logic [1:0] HIT_DOOR   = 2'd3;
  localparam logic [3:0] TEX_PILLAR = 4'd4;
  localparam logic [3:0] TEX_DOOR   = 4'd6;

  typedef struct packed {
    logic        mode;
    logic [11:0] column_x;
    logic [23:0] wall_distance;
    logic [15:0] wall_fraction;
    logic [1:0]  wall_side;
    logic [1:0]  hit_kind;
    logic [1:0]  door_frame;
  } in_word_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [3:0]  texture_index;
    logic [19:0] texel_address;
    logic        last_pixel;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LH,
    ST_CLIP,
    ST_DIV_STEP,
    ST_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic setup_load;
    logic row_tick;
    logic lh_load;
    logic clip_load;
    logic step_load;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_blocked;
  } dp_status_t;

  // texture sizes outside 1..1024 are pinned to the nearest bound
  function automatic logic [TEXD_W-1:0] tex_size(input logic [TEXD_W-1:0] v);
    logic [TEXD_W-1:0] r;
    if (v == '0) r = 11'd1;
    else if (v > TEX_SIZE_MAX) r = TEX_SIZE_MAX;
    else r = v;
    return r;
  endfunction

endpackage

// ===== hdl/textured_wall_column_walker_unit.sv =====
// textured_wall_column_walker_unit: raycaster wall column setup and per-row texel walker
// a setup word occupies the block while the bit-serial divider runs twice; a row word is
// taken every cycle while the block is idle and its output not blocked, its pixel in the
// output register in the next cycle. depends on twcw_pkg, twcw_ctrl, twcw_dp, twcw_div
// reset: synchronous active low; walker idle, output empty, registers 480 / 64 / 64
`timescale 1ns / 1ps

module textured_wall_column_walker_unit
  import twcw_pkg::*;
#(
  parameter int FRAC_BITS = TWCW_FRAC_BITS,   // fraction bits of distance and row coordinate
  parameter int ROW_BITS  = TWCW_ROW_BITS     // width of the row counters
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_wdata,
  // input words: column setup or row tick
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  // output words: one pixel per accepted row tick while a column is active
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: accepts words, steps setup through divide, clip, divide, commit
  twcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config, shared divider, clip and texture math, row walk, output register
  twcw_dp #(
    .FRAC_BITS (FRAC_BITS),
    .ROW_BITS  (ROW_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/twcw_div.sv =====
// twcw_div: restoring divider, one quotient bit per cycle
// uses twcw_pkg; instantiated by twcw_dp
`timescale 1ns / 1ps

module twcw_div
  import twcw_pkg::*;
#(
  parameter int NUM_W = TWCW_FRAC_BITS + 12,
  parameter int DEN_W_P = DEN_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W_P-1:0] den,
  output logic               done,
  output logic [NUM_W-1:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DEN_W_P-1:0] rem_r, rem_nxt;
  logic [DEN_W_P-1:0] den_r, den_nxt;
  logic [NUM_W-1:0]   quot_r, quot_nxt;

  logic [DEN_W_P:0] trial;
  logic [DEN_W_P:0] diff;
  logic             fits;

  assign trial = {rem_r, quot_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quot_nxt = num;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DEN_W_P-1:0] : trial[DEN_W_P-1:0];
      quot_nxt = {quot_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== hdl/twcw_dp.sv =====
// twcw_dp: walker datapath: config registers, column setup math, row walk, output register
// uses twcw_pkg and twcw_div; driven by twcw_ctrl commands
`timescale 1ns / 1ps

module twcw_dp
  import twcw_pkg::*;
#(
  parameter int FRAC_BITS = TWCW_FRAC_BITS,
  parameter int ROW_BITS  = TWCW_ROW_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_wdata,
  input  in_word_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  localparam int NUM_W  = FRAC_BITS + 12;
  localparam int ACC_W  = FRAC_BITS + 10;
  localparam int PROD_W = OFF_W + ACC_W;

  // configuration
  logic [11:0]       screen_height_r;
  logic [TEXD_W-1:0] texture_width_r, texture_height_r;

  // setup scratch
  logic              mirror_r, dist_zero_r;
  logic [15:0]       frac_r;
  logic [LH_W-1:0]   lh_r, lh_nxt;
  logic [11:0]       first_r, last_r;
  logic [OFF_W-1:0]  offset_r;

  // walk state
  logic                active_r;
  logic [ROW_BITS-1:0] current_row_r, end_row_r;
  logic [ACC_W-1:0]    tex_row_acc_r, tex_row_step_r;
  logic [TCOL_W-1:0]   tex_column_r;
  logic [3:0]          held_texture_r, held_texture_nxt;
  logic [11:0]         held_column_r;

  logic      out_valid_r;
  out_word_t out_data_r;

  // divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;

  logic [TEXD_W-1:0] tex_w, tex_h;
  assign tex_w = tex_size(texture_width_r);
  assign tex_h = tex_size(texture_height_r);

  assign div_start = cmd.setup_load | cmd.clip_load;
  assign div_num = cmd.setup_load ? {screen_height_r, {FRAC_BITS{1'b0}}}
                                  : {1'b0, tex_h, {FRAC_BITS{1'b0}}};
  assign div_den = cmd.setup_load ? DEN_W'(in_data.wall_distance)
                                  : DEN_W'(lh_r) + 1'b1;

  twcw_div #(.NUM_W(NUM_W), .DEN_W_P(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // texture selection by hit kind
  always_comb begin
    unique case (in_data.hit_kind)
      HIT_PILLAR: held_texture_nxt = TEX_PILLAR;
      HIT_DOOR:   held_texture_nxt = TEX_DOOR + 4'(in_data.door_frame);
      default:    held_texture_nxt = 4'(in_data.wall_side);
    endcase
  end

  // line height with saturation
  logic [NUM_W+LH_W-1:0] quot_ext;
  assign quot_ext = {{LH_W{1'b0}}, div_quot};
  always_comb begin
    if (dist_zero_r || (|quot_ext[NUM_W+LH_W-1:LH_W])) lh_nxt = LH_MAX;
    else lh_nxt = quot_ext[LH_W-1:0];
  end

  // clipping against the screen
  logic [10:0]      half_h;
  logic [OFF_W-1:0] half_lh;
  logic             top_clip;
  logic [LH_W-1:0]  bottom;
  logic [11:0]      first_c, last_c;
  logic [OFF_W-1:0] offset_c;
  assign half_h   = screen_height_r[11:1];
  assign half_lh  = lh_r[LH_W-1:1];
  assign top_clip = OFF_W'(half_h) < half_lh;
  assign bottom   = LH_W'(half_h) + LH_W'(half_lh);
  always_comb begin
    first_c  = top_clip ? 12'd0 : 12'(half_h - half_lh[10:0]);
    offset_c = top_clip ? (half_lh - OFF_W'(half_h)) : '0;
    last_c   = (bottom >= LH_W'(screen_height_r)) ? (screen_height_r - 12'd1)
                                                  : bottom[11:0];
  end

  // texture column: mirror, scale, round half up, limit
  logic [16:0] frac_m;
  logic [27:0] col_scaled;
  logic [11:0] col_round;
  logic [TCOL_W-1:0] tex_column_c;
  assign frac_m     = mirror_r ? (17'h10000 - {1'b0, frac_r}) : {1'b0, frac_r};
  assign col_scaled = 28'(frac_m) * 28'(tex_w) + 28'h8000;
  assign col_round  = col_scaled[27:16];
  always_comb begin
    if (col_round >= 12'(tex_w)) tex_column_c = TCOL_W'(tex_w - 11'd1);
    else tex_column_c = col_round[TCOL_W-1:0];
  end

  // start coordinate
  logic [PROD_W-1:0] start_prod;
  assign start_prod = PROD_W'(offset_r) * PROD_W'(tex_row_step_r);

  // row walk
  logic [20:0]      texel_mul;
  logic [20:0]      texel_sum;
  logic [ACC_W-1:0] acc_sum, acc_limit;
  logic [9:0]       tex_h_m1;
  logic             is_last;
  assign texel_mul = 21'(tex_row_acc_r[ACC_W-1:FRAC_BITS]) * 21'(tex_w);
  assign texel_sum = texel_mul + 21'(tex_column_r);
  assign tex_h_m1  = 10'(tex_h - 11'd1);
  assign acc_limit = {tex_h_m1, {FRAC_BITS{1'b0}}};
  assign acc_sum   = tex_row_acc_r + tex_row_step_r;
  assign is_last   = current_row_r == end_row_r;

  logic out_take;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r  <= SCREEN_H_RST;
      texture_width_r  <= TEX_W_RST;
      texture_height_r <= TEX_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_HEIGHT:  screen_height_r  <= cfg_wdata;
        CFG_TEXTURE_WIDTH:  texture_width_r  <= cfg_wdata[TEXD_W-1:0];
        CFG_TEXTURE_HEIGHT: texture_height_r <= cfg_wdata[TEXD_W-1:0];
        default: ;
      endcase
    end
  end

  // setup pipeline, row walk and output data registers
  always_ff @(posedge clk) begin
    if (cmd.setup_load) begin
      held_texture_r <= held_texture_nxt;
      held_column_r  <= in_data.column_x;
      frac_r         <= in_data.wall_fraction;
      mirror_r       <= !in_data.wall_side[1];
      dist_zero_r    <= in_data.wall_distance == '0;
    end
    if (cmd.lh_load) lh_r <= lh_nxt;
    if (cmd.clip_load) begin
      first_r      <= first_c;
      last_r       <= last_c;
      offset_r     <= offset_c;
      tex_column_r <= tex_column_c;
    end
    if (cmd.step_load) tex_row_step_r <= div_quot[ACC_W-1:0];
    if (cmd.commit) begin
      tex_row_acc_r <= start_prod[ACC_W-1:0];
      current_row_r <= ROW_BITS'(first_r);
      end_row_r     <= ROW_BITS'(last_r);
    end else if (cmd.row_tick && active_r) begin
      tex_row_acc_r <= (acc_sum >= acc_limit) ? acc_limit : acc_sum;
      if (!is_last) current_row_r <= current_row_r + 1'b1;
    end
    if (cmd.row_tick && active_r) begin
      out_data_r.pixel_x       <= held_column_r;
      out_data_r.pixel_y       <= 12'(current_row_r);
      out_data_r.texture_index <= held_texture_r;
      out_data_r.texel_address <= texel_sum[19:0];
      out_data_r.last_pixel    <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) active_r <= screen_height_r != 12'd0;
      else if (cmd.row_tick && active_r && is_last) active_r <= 1'b0;
      if (cmd.row_tick && active_r) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  assign status.div_done    = div_done;
  assign status.out_blocked = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/twcw_ctrl.sv =====
// twcw_ctrl: sequencing state machine for column setup and row ticks
// uses twcw_pkg; commands twcw_dp
`timescale 1ns / 1ps

module twcw_ctrl
  import twcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_mode,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = status.out_blocked;
        if (accept) begin
          if (in_mode == MODE_SETUP) begin
            cmd.setup_load = 1'b1;
            state_nxt      = ST_DIV_LH;
          end else begin
            cmd.row_tick = 1'b1;
          end
        end
      end
      ST_DIV_LH: begin
        if (status.div_done) begin
          cmd.lh_load = 1'b1;
          state_nxt   = ST_CLIP;
        end
      end
      ST_CLIP: begin
        cmd.clip_load = 1'b1;
        state_nxt     = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        if (status.div_done) begin
          cmd.step_load = 1'b1;
          state_nxt     = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sim/twcw_checker.sv =====
// twcw_checker: pixel predictor and scoreboard for the textured wall column walker
// snoops the register port and both word channels; depends on twcw_pkg
`timescale 1ns / 1ps

module twcw_checker
  import twcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_word_t  out_data,
  output int         fail_count,
  output int         pending_pixels,
  output int         pixels_checked
);

  typedef longint unsigned u64_t;

  localparam int   FB           = TWCW_FRAC_BITS;
  localparam u64_t ACC_MASK     = (64'd1 << (FB + 10)) - 1;
  localparam u64_t ROW_MASK     = (64'd1 << TWCW_ROW_BITS) - 1;
  localparam u64_t MIRROR_FACES = 2;

  // shadow registers
  logic [11:0]       screen_rows;
  logic [TEXD_W-1:0] tex_w_raw;
  logic [TEXD_W-1:0] tex_h_raw;

  // shadow walker state
  bit          walking;
  u64_t        row_now;
  u64_t        row_last;
  u64_t        tex_acc;
  u64_t        tex_step;
  logic [9:0]  tex_col;
  logic [3:0]  tex_sel;
  logic [11:0] col_held;

  out_word_t expected_pixels[$];

  initial begin
    fail_count     = 0;
    pending_pixels = 0;
    pixels_checked = 0;
  end

  function automatic u64_t clamp_tex(input logic [TEXD_W-1:0] v);
    u64_t r;
    r = u64_t'(v);
    if (r < 1) r = 1;
    if (r > 1024) r = 1024;
    return r;
  endfunction

  task automatic start_column(input in_word_t w);
    u64_t    h, tw, th, lh, xt, frac, offset;
    longint  first_r, last_r;
    h  = u64_t'(screen_rows);
    tw = clamp_tex(tex_w_raw);
    th = clamp_tex(tex_h_raw);
    case (w.hit_kind)
      HIT_PILLAR: tex_sel = TEX_PILLAR;
      HIT_DOOR:   tex_sel = TEX_DOOR + 4'(w.door_frame);
      default:    tex_sel = {2'b00, w.wall_side};
    endcase
    col_held = w.column_x;
    // zero distance saturates the line height
    if (w.wall_distance == 0) lh = u64_t'(LH_MAX);
    else begin
      lh = (h << FB) / u64_t'(w.wall_distance);
      if (lh > u64_t'(LH_MAX)) lh = u64_t'(LH_MAX);
    end
    first_r = longint'(h / 2) - longint'(lh / 2);
    last_r  = longint'(h / 2) + longint'(lh / 2);
    if (first_r < 0) first_r = 0;
    if (last_r >= longint'(h)) last_r = longint'(h) - 1;
    frac = u64_t'(w.wall_fraction);
    if (w.wall_side < MIRROR_FACES) frac = 65536 - frac;
    xt = (frac * tw + 32768) >> 16;
    if (xt >= tw) xt = tw - 1;
    tex_col  = xt[9:0];
    tex_step = ((th << FB) / (lh + 1)) & ACC_MASK;
    offset   = u64_t'(first_r) + lh / 2 - h / 2;
    tex_acc  = (offset * tex_step) & ACC_MASK;
    if (last_r < first_r) begin
      walking  = 0;
      row_now  = 0;
      row_last = 0;
    end else begin
      walking  = 1;
      row_now  = u64_t'(first_r) & ROW_MASK;
      row_last = u64_t'(last_r) & ROW_MASK;
    end
  endtask

  task automatic walk_row();
    out_word_t px;
    u64_t      tw, th, lim;
    if (!walking) return;
    tw = clamp_tex(tex_w_raw);
    th = clamp_tex(tex_h_raw);
    px.pixel_x       = col_held;
    px.pixel_y       = row_now[11:0];
    px.texture_index = tex_sel;
    px.texel_address = 20'((tex_acc >> FB) * tw + u64_t'(tex_col));
    px.last_pixel    = (row_now == row_last);
    expected_pixels.push_back(px);
    // row coordinate stops at the bottom texel row
    lim     = (th - 1) << FB;
    tex_acc = (tex_acc + tex_step) & ACC_MASK;
    if (tex_acc >= lim) tex_acc = lim;
    if (px.last_pixel) walking = 0;
    else row_now = (row_now + 1) & ROW_MASK;
  endtask

  always @(posedge clk) begin : monitor
    out_word_t want;
    if (!rst_n) begin
      screen_rows = SCREEN_H_RST;
      tex_w_raw   = TEX_W_RST;
      tex_h_raw   = TEX_H_RST;
      walking     = 0;
      row_now     = 0;
      row_last    = 0;
      tex_acc     = 0;
      tex_step    = 0;
      tex_col     = '0;
      tex_sel     = '0;
      col_held    = '0;
      expected_pixels.delete();
    end else begin
      // a pixel leaving now came from an earlier word, so compare first
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t unexpected pixel x=%0d y=%0d tex=%0d addr=%0d last=%0d", $time,
                   out_data.pixel_x, out_data.pixel_y, out_data.texture_index,
                   out_data.texel_address, out_data.last_pixel);
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (out_data !== want) begin
            fail_count++;
            $display("%0t pixel mismatch expected x=%0d y=%0d tex=%0d addr=%0d last=%0d",
                     $time, want.pixel_x, want.pixel_y, want.texture_index,
                     want.texel_address, want.last_pixel);
            $display("%0t                actual   x=%0d y=%0d tex=%0d addr=%0d last=%0d",
                     $time, out_data.pixel_x, out_data.pixel_y, out_data.texture_index,
                     out_data.texel_address, out_data.last_pixel);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_HEIGHT:  screen_rows = cfg_wdata;
          CFG_TEXTURE_WIDTH:  tex_w_raw   = cfg_wdata[TEXD_W-1:0];
          CFG_TEXTURE_HEIGHT: tex_h_raw   = cfg_wdata[TEXD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.mode == MODE_SETUP) start_column(in_data);
        else walk_row();
      end
    end
    pending_pixels = expected_pixels.size();
  end

endmodule

// ===== sim/testbench.sv =====
// testbench: stimulus and verdict for textured_wall_column_walker_unit
// drives setup and row words, register writes and output stalls; depends on twcw_pkg
// and twcw_checker, which predicts and compares every pixel word
`timescale 1ns / 1ps

module testbench;
  import twcw_pkg::*;

  // a setup keeps the block busy while its two divisions run, plus margin
  localparam int SETTLE_CYCLES = 90;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 110;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SCREEN_HEIGHT;
  logic [11:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;

  int  fail_count;
  int  pending_pixels;
  int  pixels_checked;
  int  words_sent = 0;
  int  settings_used = 1;
  int  burst_left = 0;
  bit  hold_req = 0;

  textured_wall_column_walker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  twcw_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_pixels (pending_pixels),
    .pixels_checked (pixels_checked)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop if the handshakes ever hang
  initial begin
    #4_000_000;
    $display("timeout with %0d pixels still expected", pending_pixels);
    $display("FAIL");
    $finish;
  end

  // receiver: picks a new stall pattern after each random run; a hold request
  // from the sender side freezes the output for a long counted stretch
  initial begin : receiver
    int pattern_sel;
    int pattern_left;
    int hold_left;
    pattern_sel  = 0;
    pattern_left = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_sel  = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (pattern_sel)
          0:       out_stall <= 1'b0;                        // free flowing
          1:       out_stall <= ($urandom_range(0, 3) == 0); // light stalls
          2:       out_stall <= ($urandom_range(0, 3) != 0); // heavy stalls
          default: out_stall <= ~out_stall;                  // alternating stalls
        endcase
      end
    end
  end

  // present one word and hold it until taken; valid stays high afterwards so a
  // following word in the same burst goes out back to back
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // sender bursts: random length, random gaps, now and then a long unbroken run
  task automatic offer(input in_word_t w);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    send_word(w);
    burst_left--;
  endtask

  // wait for every expected pixel, then let any setup still in flight finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // only called with the block drained
  task automatic set_regs(input logic [11:0] rows, input logic [11:0] tw,
                          input logic [11:0] th);
    write_reg(CFG_SCREEN_HEIGHT, rows);
    write_reg(CFG_TEXTURE_WIDTH, tw);
    write_reg(CFG_TEXTURE_HEIGHT, th);
    settings_used++;
  endtask

  function automatic in_word_t setup_word(input logic [11:0] col, input logic [23:0] wall_dist,
                                          input logic [15:0] frac, input logic [1:0] side,
                                          input logic [1:0] hit, input logic [1:0] door);
    in_word_t w;
    w.mode          = MODE_SETUP;
    w.column_x      = col;
    w.wall_distance = wall_dist;
    w.wall_fraction = frac;
    w.wall_side     = side;
    w.hit_kind      = hit;
    w.door_frame    = door;
    return w;
  endfunction

  // row tick with junk in the unused fields
  function automatic in_word_t tick_word();
    in_word_t w;
    w               = setup_word(12'($urandom), 24'($urandom), 16'($urandom),
                                 2'($urandom), 2'($urandom), 2'($urandom));
    w.mode          = MODE_ROW;
    return w;
  endfunction

  // distances spread over near walls (tall clipped lines), the usual range,
  // the full field and the edges
  function automatic in_word_t rand_setup();
    logic [23:0] wall_dist;
    int          pick;
    pick = $urandom_range(0, 19);
    if (pick < 5)       wall_dist = 24'($urandom_range(1, 24'h00FFFF));
    else if (pick < 13) wall_dist = 24'($urandom_range(24'h020000, 24'h400000));
    else if (pick < 18) wall_dist = 24'($urandom);
    else if (pick == 18) wall_dist = '0;
    else                wall_dist = '1;
    return setup_word(12'($urandom), wall_dist, 16'($urandom), 2'($urandom), 2'($urandom),
                      2'($urandom));
  endfunction

  // mostly a setup followed by a run of row ticks; the rest is idle ticks
  // and setups that cut a column short
  task automatic random_words(input int count);
    int done;
    int pick;
    int rows;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        offer(rand_setup());
        rows = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        repeat (rows) offer(tick_word());
        done += rows + 1;
      end else if (pick == 7) begin
        rows = $urandom_range(1, 5);
        repeat (rows) offer(tick_word());
        done += rows;
      end else begin
        offer(rand_setup());
        offer(rand_setup());
        done += 2;
      end
    end
  endtask

  initial begin : stimulus
    int       phase;
    logic [11:0] rows;
    logic [11:0] tw;
    logic [11:0] th;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words under the reset registers (480 rows, 64x64 texels)
    offer(tick_word());                                           // idle tick
    offer(setup_word(12'd0, 24'hFFFFFF, 16'h0000, 2'd0, 2'd0, 2'd0)); // one row, column pinned
    offer(tick_word());
    offer(tick_word());                                           // column already done
    offer(setup_word(12'hFFF, 24'h000000, 16'hFFFF, 2'd3, HIT_DOOR, 2'd3)); // zero distance
    repeat (3) offer(tick_word());
    offer(setup_word(12'h555, 24'h0A0000, 16'h8000, 2'd2, HIT_PILLAR, 2'd1)); // replaces column
    repeat (4) offer(tick_word());
    offer(setup_word(12'hAAA, 24'h008000, 16'h7FFF, 2'd1, 2'd1, 2'd2)); // clipped top
    repeat (4) offer(tick_word());
    offer(setup_word(12'd7, 24'h000001, 16'h0001, 2'd0, 2'd0, 2'd0)); // quotient saturates
    repeat (2) offer(tick_word());
    offer(setup_word(12'd1, 24'hF00000, 16'h1234, 2'd3, 2'd0, 2'd0)); // three rows, then idle
    repeat (4) offer(tick_word());
    drain();

    // a column longer than the hold: the output backs up into the input
    offer(setup_word(12'd100, 24'h004000, 16'($urandom), 2'd2, 2'd1, 2'd0));
    hold_req   = 1;
    burst_left = 1000;
    repeat (60) offer(tick_word());
    drain();

    // register settings: both extremes, empty screen with out-of-range
    // texture sizes, then random ones; columns left open carry across
    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin rows = 12'd1;    tw = 12'd1;    th = 12'd1;    end
        1: begin rows = 12'd4095; tw = 12'd1024; th = 12'd1024; end
        2: begin rows = 12'd0;    tw = 12'd0;    th = 12'hFFF;  end
        3: begin rows = 12'd64;   tw = 12'd13;   th = 12'd100;  end
        default: begin
          rows = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095))
                                             : 12'($urandom_range(8, 300));
          tw   = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1, 1024));
          th   = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1, 1024));
        end
      endcase
      set_regs(rows, tw, th);
      random_words((phase == 2) ? 40 : PHASE_WORDS);
      drain();
    end

    // back to the reset values for a last stretch
    set_regs(SCREEN_H_RST, 12'(TEX_W_RST), 12'(TEX_H_RST));
    random_words(PHASE_WORDS);
    drain();

    $display("covered %0d input words across %0d register settings", words_sent,
             settings_used);
    $display("%0d pixel words compared, with output holds and input back-pressure",
             pixels_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
